>>> rtl/core/afhf_pkg.sv
`default_nettype none
package afhf_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [1:0] {
		KIND_HEADER   = 2'd0,
		KIND_NAME     = 2'd1,
		KIND_NAME_END = 2'd2,
		KIND_PAYLOAD  = 2'd3
	} afhf_kind_t;

	// Sequencer states of the framer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_DIGITS,
		ST_COLON,
		ST_END_COLON
	} afhf_state_t;

	// Header number being serialized
	localparam logic [1:0] FLD_TOTAL  = 2'd0;
	localparam logic [1:0] FLD_NUMBER = 2'd1;
	localparam logic [1:0] FLD_SIZE   = 2'd2;

	localparam logic [15:0] MAX_PAYLOAD = 16'd1000;
	localparam logic [7:0]  ZERO_CHAR   = 8'h30;
	localparam logic [7:0]  COLON_CHAR  = 8'h3A;
	localparam logic [7:0]  NUL_CHAR    = 8'h00;

	// floor(v / 10) == (v * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit v
	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int          DIV10_SHIFT = 35;
	localparam int          MAX_DIGITS  = 10;

	// Request from the sequencer to the decimal converter
	typedef struct packed {
		logic        start;
		logic        pop;
		logic [31:0] value;
	} afhf_conv_req_t;

	// Converter status back to the sequencer
	typedef struct packed {
		logic       busy;
		logic [3:0] cnt;
		logic [3:0] digit;
	} afhf_conv_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/ascii_fragment_header_framer.sv
// Fragment framer: turns a stream of requests into the bytes of one
// file-transfer fragment.
// Input channel s_axis: tuser holds the kind (header, name byte, end of
// name, payload byte); tdata holds the header numbers and the byte.
// Output channel m_axis: one byte per transfer in tdata, tlast on the last
// byte caused by a request, tuser[0] on the final payload byte of the
// fragment.
// Name and payload bytes: accepted, then shown on the next cycle, one per
// cycle while the output is not stalled. End of name: a NUL byte, then a
// colon. Payload bytes beyond the size given in the header are dropped.
// Header: each of the three numbers is converted by one shared
// divide-by-ten unit (multiply by reciprocal), then its digits and colon
// are sent, one per cycle while the output is not stalled; a zero number
// sends only its colon. No request is taken while a header is converted
// and sent.
// A stalled receiver holds the output register and the block waits; no
// request is taken while the output register is full and not drained.
// Reset clears the stored payload size and count, so payload bytes before
// the first header are dropped.
`default_nettype none
module ascii_fragment_header_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: total_count[31:0], fragment_number[63:32], payload_size[73:64],
	//        byte_value[81:74], zero fill[87:82]
	input  wire logic [87:0] s_axis_tdata,
	// tuser: kind[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: out_byte[7:0]
	output logic [7:0]       m_axis_tdata,
	output logic             m_axis_tlast,
	// tuser: packet_end[0]
	output logic [0:0]       m_axis_tuser
);

	afhf_pkg::afhf_state_t     state_q, state_d;
	afhf_pkg::afhf_conv_req_t  conv_req;
	afhf_pkg::afhf_conv_stat_t conv_stat;
	afhf_pkg::afhf_kind_t      kind;

	logic [31:0] total;
	logic [31:0] frag_num;
	logic [9:0]  size;
	logic [7:0]  byte_in;

	logic [31:0] num_q;
	logic [9:0]  size_q;
	logic [1:0]  fld_q;
	logic [9:0]  exp_q;
	logic [9:0]  seen_q;
	logic        m_valid_q;
	logic [7:0]  m_byte_q;
	logic        m_last_q;
	logic        m_pend_q;

	logic        load_ok;
	logic        accept;
	logic        load;
	logic [7:0]  ld_byte;
	logic        ld_last;
	logic        ld_pend;
	logic        hdr_load;
	logic        seen_inc;
	logic        fld_inc;
	logic [9:0]  exp_d;
	logic [9:0]  seen_next;

	assign total    = s_axis_tdata[31:0];
	assign frag_num = s_axis_tdata[63:32];
	assign size     = s_axis_tdata[73:64];
	assign byte_in  = s_axis_tdata[81:74];
	assign kind     = afhf_pkg::afhf_kind_t'(s_axis_tuser);

	assign load_ok   = !m_valid_q || m_axis_tready;
	assign seen_next = seen_q + 10'd1;
	assign exp_d     = ({6'b0, size} > afhf_pkg::MAX_PAYLOAD) ?
		afhf_pkg::MAX_PAYLOAD[9:0] : size;

	// Shared decimal converter
	afhf_dec_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (conv_req),
		.stat   (conv_stat)
	);

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= afhf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence requests, conversions and output bytes
	always_comb begin
		state_d        = state_q;
		s_axis_tready  = 1'b0;
		accept         = 1'b0;
		load           = 1'b0;
		ld_byte        = afhf_pkg::NUL_CHAR;
		ld_last        = 1'b0;
		ld_pend        = 1'b0;
		hdr_load       = 1'b0;
		seen_inc       = 1'b0;
		fld_inc        = 1'b0;
		conv_req.start = 1'b0;
		conv_req.pop   = 1'b0;
		conv_req.value = total;
		unique case (state_q)
			afhf_pkg::ST_IDLE: begin
				s_axis_tready = load_ok;
				accept        = s_axis_tvalid && load_ok;
				if (accept) begin
					unique case (kind)
						afhf_pkg::KIND_HEADER: begin
							hdr_load       = 1'b1;
							conv_req.start = 1'b1;
							conv_req.value = total;
							state_d        = afhf_pkg::ST_CONV;
						end
						afhf_pkg::KIND_NAME: begin
							load    = 1'b1;
							ld_byte = byte_in;
							ld_last = 1'b1;
						end
						afhf_pkg::KIND_NAME_END: begin
							load    = 1'b1;
							ld_byte = afhf_pkg::NUL_CHAR;
							state_d = afhf_pkg::ST_END_COLON;
						end
						afhf_pkg::KIND_PAYLOAD: begin
							// drop bytes beyond the announced size
							if (seen_q < exp_q) begin
								load     = 1'b1;
								ld_byte  = byte_in;
								ld_last  = 1'b1;
								ld_pend  = (seen_next == exp_q);
								seen_inc = 1'b1;
							end
						end
					endcase
				end
			end
			afhf_pkg::ST_CONV: begin
				if (!conv_stat.busy) begin
					state_d = afhf_pkg::ST_DIGITS;
				end
			end
			afhf_pkg::ST_DIGITS: begin
				if (conv_stat.cnt == 4'd0) begin
					state_d = afhf_pkg::ST_COLON;
				end else if (load_ok) begin
					load         = 1'b1;
					ld_byte      = afhf_pkg::ZERO_CHAR + {4'b0, conv_stat.digit};
					conv_req.pop = 1'b1;
					if (conv_stat.cnt == 4'd1) begin
						state_d = afhf_pkg::ST_COLON;
					end
				end
			end
			afhf_pkg::ST_COLON: begin
				if (load_ok) begin
					load    = 1'b1;
					ld_byte = afhf_pkg::COLON_CHAR;
					ld_last = (fld_q == afhf_pkg::FLD_SIZE);
					if (fld_q == afhf_pkg::FLD_SIZE) begin
						state_d = afhf_pkg::ST_IDLE;
					end else begin
						conv_req.start = 1'b1;
						conv_req.value = (fld_q == afhf_pkg::FLD_TOTAL) ?
							num_q : {22'b0, size_q};
						fld_inc        = 1'b1;
						state_d        = afhf_pkg::ST_CONV;
					end
				end
			end
			afhf_pkg::ST_END_COLON: begin
				if (load_ok) begin
					load    = 1'b1;
					ld_byte = afhf_pkg::COLON_CHAR;
					ld_last = 1'b1;
					state_d = afhf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = afhf_pkg::ST_IDLE;
			end
		endcase
	end

	// Track the payload count, the header field under conversion and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q     <= '0;
			seen_q    <= '0;
			fld_q     <= afhf_pkg::FLD_TOTAL;
			m_valid_q <= 1'b0;
		end else begin
			if (hdr_load) begin
				exp_q  <= exp_d;
				seen_q <= '0;
				fld_q  <= afhf_pkg::FLD_TOTAL;
			end else begin
				if (seen_inc) begin
					seen_q <= seen_next;
				end
				if (fld_inc) begin
					fld_q <= fld_q + 2'd1;
				end
			end
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Hold the header numbers and the output payload
	always_ff @(posedge clk) begin
		if (hdr_load) begin
			num_q  <= frag_num;
			size_q <= size;
		end
		if (load) begin
			m_byte_q <= ld_byte;
			m_last_q <= ld_last;
			m_pend_q <= ld_pend;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_byte_q;
	assign m_axis_tlast    = m_last_q;
	assign m_axis_tuser[0] = m_pend_q;

endmodule
`default_nettype wire

>>> rtl/core/afhf_dec_conv.sv
`default_nettype none
module afhf_dec_conv (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire afhf_pkg::afhf_conv_req_t req,
	output afhf_pkg::afhf_conv_stat_t     stat
);

	localparam int QW = 64 - afhf_pkg::DIV10_SHIFT;

	logic        busy_q;
	logic        phase_q;
	logic [3:0]  cnt_q;
	logic [31:0] v_q;
	logic [63:0] prod_q;
	logic [3:0]  stk_q [afhf_pkg::MAX_DIGITS];

	logic [QW-1:0] quot;
	logic [3:0]    rem;

	// Quotient from the registered product, remainder by shift-add on the low bits
	always_comb begin
		quot = prod_q[63:afhf_pkg::DIV10_SHIFT];
		rem  = v_q[3:0] - ({quot[0], 3'b000} + {quot[2:0], 1'b0});
	end

	// Control: alternate product and update phases until v is zero; pops count down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (req.start) begin
			busy_q  <= (req.value != '0);
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (busy_q) begin
			phase_q <= ~phase_q;
			if (phase_q) begin
				cnt_q  <= cnt_q + 4'd1;
				busy_q <= (quot != '0);
			end
		end else if (req.pop) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	// Datapath: value, product and the digit stack (least significant pushed first)
	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q <= req.value;
		end else if (busy_q) begin
			if (!phase_q) begin
				prod_q <= v_q * afhf_pkg::DIV10_RECIP;
			end else begin
				v_q      <= {{(32-QW){1'b0}}, quot};
				stk_q[0] <= rem;
				for (int i = 1; i < afhf_pkg::MAX_DIGITS; i++) begin
					stk_q[i] <= stk_q[i-1];
				end
			end
		end else if (req.pop) begin
			for (int i = 0; i < afhf_pkg::MAX_DIGITS - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
	end

	assign stat.busy  = busy_q;
	assign stat.cnt   = cnt_q;
	assign stat.digit = stk_q[0];

endmodule
`default_nettype wire

>>> rtl/core/afhf_checker.sv
`default_nettype none
module afhf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [87:0] s_axis_tdata,
	input wire logic [1:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic [0:0]  m_axis_tuser
);

	// A stalled byte stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output byte withdrawn while stalled");

	// Packet end only on the last byte of a request
	a_pend_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("packet end without tlast");

	// No request taken while the output register is blocked
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
		else $error("request taken with output blocked");

	// A name byte passes through on the next cycle
	a_name_pass: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == afhf_pkg::KIND_NAME)
		|=> m_axis_tvalid && m_axis_tlast && (m_axis_tdata == $past(s_axis_tdata[81:74])))
		else $error("name byte not passed through");

	// A taken header closes the input
	a_hdr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == afhf_pkg::KIND_HEADER)
		|=> !s_axis_tready)
		else $error("request taken during header conversion");

endmodule

bind ascii_fragment_header_framer afhf_checker u_afhf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

>>> tb/sv/tb_ascii_fragment_header_framer.sv
`timescale 1ns / 100ps

module tb_ascii_fragment_header_framer;
	import afhf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          SETTLE      = 150;

	// One request on the input stream
	typedef struct packed {
		afhf_kind_t  kind;
		logic [31:0] total;
		logic [31:0] number;
		logic [9:0]  size;
		logic [7:0]  value;
	} frag_req_t;

	// One serialized byte on the output stream
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       pend;
	} frag_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;

	// Framer state as seen from outside
	logic [9:0] due_bytes = '0;
	logic [9:0] seen_bytes = '0;

	frag_byte_t  framed_q[$];
	frag_byte_t  pending_q[$];
	frag_byte_t  got_byte;
	int          mismatches = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	int unsigned cycle_cnt = 0;

	// Directed table
	frag_req_t plan_q[$];
	bit        plan_pinned_q[$];
	string     plan_text_q[$];

	ascii_fragment_header_framer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// Append the decimal digits of v, then its colon
	function automatic void push_decimal(input logic [31:0] v, input bit closes);
		logic [7:0] digits[$];
		while (v != 0) begin
			digits.push_front(ZERO_CHAR + 8'(v % 10));
			v = v / 10;
		end
		foreach (digits[j])
			framed_q.push_back({digits[j], 1'b0, 1'b0});
		framed_q.push_back({COLON_CHAR, closes, 1'b0});
	endfunction

	// Work out the bytes one request causes and advance the payload count
	function automatic void frame_request(input frag_req_t r);
		case (r.kind)
			KIND_HEADER: begin
				push_decimal(r.total, 1'b0);
				push_decimal(r.number, 1'b0);
				push_decimal({22'd0, r.size}, 1'b1);
				due_bytes  = ({6'd0, r.size} > MAX_PAYLOAD) ? MAX_PAYLOAD[9:0] : r.size;
				seen_bytes = '0;
			end
			KIND_NAME: framed_q.push_back({r.value, 1'b1, 1'b0});
			KIND_NAME_END: begin
				framed_q.push_back({NUL_CHAR, 1'b0, 1'b0});
				framed_q.push_back({COLON_CHAR, 1'b1, 1'b0});
			end
			default: begin
				if (seen_bytes < due_bytes) begin
					seen_bytes = seen_bytes + 10'd1;
					framed_q.push_back({r.value, 1'b1, seen_bytes == due_bytes});
				end
			end
		endcase
	endfunction

	// Fully random request, every field and kind
	function automatic frag_req_t noise_req();
		frag_req_t r;
		r.kind   = afhf_kind_t'($urandom_range(3));
		r.total  = $urandom;
		r.number = $urandom;
		r.size   = 10'($urandom_range(1023));
		r.value  = 8'($urandom_range(255));
		return r;
	endfunction

	// Header number spread over all digit counts
	function automatic logic [31:0] rand_number();
		case ($urandom_range(4))
			0: return $urandom_range(9);
			1: return $urandom_range(9999);
			2: return 32'hFFFF_FFFF - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	// Mostly small payload sizes
	function automatic logic [9:0] rand_size();
		case ($urandom_range(9))
			0: return 10'd0;
			1, 2: return 10'($urandom_range(1023));
			default: return 10'($urandom_range(1, 8));
		endcase
	endfunction

	task automatic add_row(input afhf_kind_t k, input logic [31:0] tf, input logic [31:0] fn,
			input logic [9:0] sz, input logic [7:0] bv, input bit pinned, input string text);
		plan_q.push_back({k, tf, fn, sz, bv});
		plan_pinned_q.push_back(pinned);
		plan_text_q.push_back(text);
	endtask

	// Offer one request, hold it until taken, then record what it should produce
	task automatic send_req(input frag_req_t r, input bit pinned, input string text);
		int i;
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, r.value, r.size, r.number, r.total};
		s_axis_tuser  <= r.kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		framed_q.delete();
		frame_request(r);
		if (pinned) begin
			framed_q.delete();
			for (i = 0; i < text.len(); i++)
				framed_q.push_back({text[i], i == text.len() - 1, 1'b0});
		end
		foreach (framed_q[j])
			pending_q.push_back(framed_q[j]);
	endtask

	// Well-formed fragments with random content, mixed with noise
	task automatic random_phase(input int budget);
		int sent;
		int k;
		int names;
		int pays;
		logic [9:0] sz;
		frag_req_t r;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99) < 80) begin
				r = noise_req();
				r.kind   = KIND_HEADER;
				r.total  = rand_number();
				r.number = rand_number();
				r.size   = rand_size();
				sz       = r.size;
				send_req(r, 1'b0, "");
				names = $urandom_range(6);
				for (k = 0; k < names; k++) begin
					r = noise_req();
					r.kind = KIND_NAME;
					send_req(r, 1'b0, "");
				end
				if ($urandom_range(9) != 0) begin
					r = noise_req();
					r.kind = KIND_NAME_END;
					send_req(r, 1'b0, "");
				end
				// cut some fragments short, overrun others
				if (sz > 10'd8)
					pays = $urandom_range(1, 6);
				else if ($urandom_range(9) == 0)
					pays = $urandom_range(sz);
				else
					pays = sz + $urandom_range(2);
				for (k = 0; k < pays; k++) begin
					r = noise_req();
					r.kind = KIND_PAYLOAD;
					send_req(r, 1'b0, "");
				end
				sent += 2 + names + pays;
			end else begin
				send_req(noise_req(), 1'b0, "");
				sent++;
			end
		end
	endtask

	// Randomly stall the output
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall);

	// Compare each taken byte with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected byte: expected none, actual %h last %b end %b",
					$time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
			end else begin
				got_byte = pending_q.pop_front();
				if (m_axis_tdata !== got_byte.data) begin
					mismatches++;
					$display("%0t: byte: expected %h, actual %h", $time, got_byte.data, m_axis_tdata);
				end
				if (m_axis_tlast !== got_byte.last) begin
					mismatches++;
					$display("%0t: tlast: expected %b, actual %b", $time, got_byte.last, m_axis_tlast);
				end
				if (m_axis_tuser[0] !== got_byte.pend) begin
					mismatches++;
					$display("%0t: packet end: expected %b, actual %b",
						$time, got_byte.pend, m_axis_tuser[0]);
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("ascii_fragment_header_framer verification failed");
			$finish;
		end
	end

	initial begin
		int i;
		int ph;
		frag_req_t r;

		// kind, total, number, size, byte, pinned, expected text
		add_row(KIND_PAYLOAD,  32'd0, 32'd0, 10'd0, 8'hAA, 1'b1, "");
		add_row(KIND_HEADER,   32'd0, 32'd0, 10'd0, 8'h00, 1'b1, ":::");
		add_row(KIND_PAYLOAD,  32'd0, 32'd0, 10'd0, 8'h55, 1'b1, "");
		add_row(KIND_HEADER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 8'h00, 1'b1,
			"4294967295:4294967295:1023:");
		add_row(KIND_NAME,     32'd0, 32'd0, 10'd0, 8'h00, 1'b0, "");
		add_row(KIND_NAME,     32'd0, 32'd0, 10'd0, 8'hFF, 1'b0, "");
		add_row(KIND_NAME,     32'd0, 32'd0, 10'd0, 8'h41, 1'b0, "");
		add_row(KIND_NAME_END, 32'd0, 32'd0, 10'd0, 8'h00, 1'b0, "");
		add_row(KIND_PAYLOAD,  32'd0, 32'd0, 10'd0, 8'h00, 1'b0, "");
		add_row(KIND_HEADER,   32'd1, 32'd1, 10'd1, 8'h00, 1'b1, "1:1:1:");
		add_row(KIND_PAYLOAD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 8'hFF, 1'b0, "");
		add_row(KIND_PAYLOAD,  32'd0, 32'd0, 10'd0, 8'h7E, 1'b1, "");
		add_row(KIND_HEADER,   32'd10, 32'd1_000_000_000, 10'd1000, 8'h00, 1'b1,
			"10:1000000000:1000:");
		add_row(KIND_HEADER,   32'd3, 32'd2, 10'd2, 8'hFF, 1'b1, "3:2:2:");
		add_row(KIND_NAME,     32'hFFFF_FFFF, 32'd7, 10'd9, 8'h61, 1'b0, "");
		add_row(KIND_NAME_END, 32'd5, 32'd5, 10'd5, 8'hFF, 1'b0, "");
		add_row(KIND_PAYLOAD,  32'd0, 32'd0, 10'd0, 8'h80, 1'b0, "");
		add_row(KIND_PAYLOAD,  32'd0, 32'd0, 10'd0, 8'h01, 1'b0, "");
		add_row(KIND_PAYLOAD,  32'd0, 32'd0, 10'd0, 8'h99, 1'b1, "");
		add_row(KIND_HEADER,   32'd9, 32'd99, 10'd512, 8'h00, 1'b1, "9:99:512:");
		add_row(KIND_NAME_END, 32'd0, 32'd0, 10'd0, 8'h00, 1'b0, "");
		add_row(KIND_PAYLOAD,  32'd0, 32'd0, 10'd0, 8'h3C, 1'b0, "");

		// hold reset low, then release it
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < plan_q.size(); i++)
			send_req(plan_q[i], plan_pinned_q[i], plan_text_q[i]);

		for (ph = 0; ph < 4; ph++) begin
			// hold off until every byte so far has come out
			if (pending_q.size() != 0) begin
				s_axis_tvalid <= 1'b0;
				while (pending_q.size() != 0)
					@(posedge clk);
			end
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 73; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 73; end
				default: begin send_idle = 10; recv_stall = 10; end
			endcase
			if (ph == 0) begin
				// oversized size: digits keep the value, count saturates
				r = noise_req();
				r.kind = KIND_HEADER;
				r.size = 10'($urandom_range(1001, 1023));
				send_req(r, 1'b0, "");
				for (i = 0; i < 4; i++) begin
					r = noise_req();
					r.kind = KIND_PAYLOAD;
					send_req(r, 1'b0, "");
				end
			end
			random_phase(110);
		end
		s_axis_tvalid <= 1'b0;

		// drain, then give the block time to show anything stray
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && pending_q.size() == 0)
			$display("ascii_fragment_header_framer verification clean");
		else
			$display("ascii_fragment_header_framer verification failed");
		$finish;
	end

endmodule

>>> files.f
rtl/core/afhf_pkg.sv
rtl/core/afhf_dec_conv.sv
rtl/core/ascii_fragment_header_framer.sv
rtl/core/afhf_checker.sv
tb/sv/tb_ascii_fragment_header_framer.sv
